@@ sv/ctt_pkg.sv @@
// Package for the configuration text tokenizer: position types, character codes,
// result word and bundle types, and the saturating counter helpers.
// No dependencies.
`default_nettype none

package ctt_pkg;

    // Width of the line and column counters
    localparam int POS_BITS  = 16;
    // Width of the reported line and column fields
    localparam int OUT_BITS  = 16;
    // Most result words one text byte can cause
    localparam int MAX_ITEMS = 4;
    localparam int CNT_BITS  = $clog2(MAX_ITEMS + 1);
    localparam int IDX_BITS  = $clog2(MAX_ITEMS);

    localparam longint unsigned POS_MAX = (64'd1 << POS_BITS) - 64'd1;
    localparam longint unsigned OUT_LIM = (64'd1 << OUT_BITS) - 64'd1;
    localparam longint unsigned OUT_MAX = (POS_MAX < OUT_LIM) ? POS_MAX : OUT_LIM;

    typedef logic [POS_BITS-1:0] t_pos;
    typedef logic [OUT_BITS-1:0] t_opos;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Result word kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        t_opos      line;
        t_opos      col;
    } t_item;

    // All result words caused by one text byte
    typedef struct packed {
        logic [CNT_BITS-1:0]        cnt;
        t_item [MAX_ITEMS-1:0]      items;
    } t_bundle;

    // Counter increment that sticks at all ones
    function automatic t_pos sat_inc(input t_pos v);
        return (v == {POS_BITS{1'b1}}) ? v : (v + t_pos'(1));
    endfunction

    // 0-based counter to 1-based reported position, clipped
    function automatic t_opos out_pos(input t_pos v);
        t_opos p;
        if (64'(v) >= OUT_MAX) begin
            p = t_opos'(OUT_MAX);
        end else begin
            // below the clip point, so v + 1 still fits the counter width
            p = t_opos'(v + t_pos'(1));
        end
        return p;
    endfunction

endpackage

`default_nettype wire

@@ sv/ctt_if.sv @@
// Channel interfaces of the tokenizer: text byte input and token word output.
// Depends on nothing; valid/ready handshake on each.
`default_nettype none

interface ctt_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ctt_token_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  token_char;
    logic [15:0] token_line;
    logic [15:0] token_col;
    logic        last_of_run;

    modport source (output valid, output item_kind, output token_char, output token_line,
                    output token_col, output last_of_run, input ready);
    modport sink   (input valid, input item_kind, input token_char, input token_line,
                    input token_col, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ sv/ctt_lexer.sv @@
// Tokenizer state and single-pass scan: turns one text byte into a bundle of
// up to four result words. Depends on ctt_pkg and ctt_text_if.
`default_nettype none

module ctt_lexer (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    ctt_text_if.sink          i_text,
    input  wire logic         i_bun_ready,
    output ctt_pkg::t_bundle  o_bun,
    output logic              o_bun_valid
);
    import ctt_pkg::*;

    logic r_comm, r_quote, r_slash, r_open;
    t_pos r_scol, r_line, r_colc, r_hcol;
    logic n_comm, n_quote, n_slash, n_open;
    t_pos n_scol, n_line, n_colc, n_hcol;

    logic [7:0] b;
    logic       eot, lf, fire;
    logic       i_ready_w;
    t_opos      line_o;
    t_bundle    bun;

    assign i_ready_w    = i_bun_ready;
    assign i_text.ready = i_ready_w;

    assign b      = i_text.text_byte;
    assign eot    = i_text.end_of_text;
    assign lf     = (b == CH_LF);
    assign fire   = i_text.valid && i_ready_w;
    assign line_o = out_pos(r_line);

    // Scan of one byte, in the order the words leave
    always_comb begin
        logic [CNT_BITS-1:0] n;
        logic                punct, blank;
        n       = '0;
        bun     = '0;
        n_comm  = r_comm;
        n_quote = r_quote;
        n_slash = r_slash;
        n_open  = r_open;
        n_scol  = r_scol;
        n_line  = r_line;
        n_colc  = r_colc;
        n_hcol  = r_hcol;
        punct   = (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_COMMA) || (b == CH_EQUALS);
        blank   = (b == CH_SPACE) || (b == CH_TAB);

        // held slash turns out to be an ordinary character
        if (r_slash && (eot || lf || (b != CH_SLASH))) begin
            if (!n_open) begin
                n_open = 1'b1;
                n_scol = r_hcol;
            end
            bun.items[n[IDX_BITS-1:0]] = '{KIND_CHAR, CH_SLASH, line_o, out_pos(n_scol)};
            n = n + CNT_BITS'(1);
            n_slash = 1'b0;
        end

        if (eot || lf) begin
            if (n_open) begin
                bun.items[n[IDX_BITS-1:0]] = '{KIND_END, 8'h00, line_o, out_pos(n_scol)};
                n = n + CNT_BITS'(1);
            end
            n_open  = 1'b0;
            n_comm  = 1'b0;
            n_quote = 1'b0;
            n_slash = 1'b0;
            n_colc  = '0;
            if (eot) begin
                n_scol = '0;
                n_line = '0;
                n_hcol = '0;
            end else begin
                n_line = sat_inc(r_line);
            end
        end else if (r_comm) begin
            n_colc = sat_inc(r_colc);
        end else if (r_slash && (b == CH_SLASH)) begin
            // comment start closes the pending token
            if (n_open) begin
                bun.items[n[IDX_BITS-1:0]] = '{KIND_END, 8'h00, line_o, out_pos(n_scol)};
                n = n + CNT_BITS'(1);
            end
            n_open  = 1'b0;
            n_slash = 1'b0;
            n_comm  = 1'b1;
            n_colc  = sat_inc(r_colc);
        end else begin
            n_colc = sat_inc(r_colc);
            if (b == CH_SLASH) begin
                n_slash = 1'b1;
                n_hcol  = r_colc;
            end else if (b != CH_CR) begin
                if (b == CH_QUOTE) begin
                    n_quote = !r_quote;
                end
                if (punct) begin
                    if (n_open) begin
                        bun.items[n[IDX_BITS-1:0]] =
                            '{KIND_END, 8'h00, line_o, out_pos(n_scol)};
                        n = n + CNT_BITS'(1);
                    end
                    n_open = 1'b0;
                    bun.items[n[IDX_BITS-1:0]] = '{KIND_CHAR, b, line_o, out_pos(r_colc)};
                    n = n + CNT_BITS'(1);
                    bun.items[n[IDX_BITS-1:0]] = '{KIND_END, 8'h00, line_o, out_pos(r_colc)};
                    n = n + CNT_BITS'(1);
                end else if (blank && !n_quote) begin
                    if (n_open) begin
                        bun.items[n[IDX_BITS-1:0]] =
                            '{KIND_END, 8'h00, line_o, out_pos(n_scol)};
                        n = n + CNT_BITS'(1);
                    end
                    n_open = 1'b0;
                end else begin
                    if (!n_open) begin
                        n_open = 1'b1;
                        n_scol = r_colc;
                    end
                    bun.items[n[IDX_BITS-1:0]] = '{KIND_CHAR, b, line_o, out_pos(n_scol)};
                    n = n + CNT_BITS'(1);
                end
            end
        end
        bun.cnt = n;
    end

    // State update on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comm  <= 1'b0;
            r_quote <= 1'b0;
            r_slash <= 1'b0;
            r_open  <= 1'b0;
            r_scol  <= '0;
            r_line  <= '0;
            r_colc  <= '0;
            r_hcol  <= '0;
        end else if (fire) begin
            r_comm  <= n_comm;
            r_quote <= n_quote;
            r_slash <= n_slash;
            r_open  <= n_open;
            r_scol  <= n_scol;
            r_line  <= n_line;
            r_colc  <= n_colc;
            r_hcol  <= n_hcol;
        end
    end

    assign o_bun       = bun;
    assign o_bun_valid = fire;

endmodule

`default_nettype wire

@@ sv/ctt_drain.sv @@
// Two-stage bundle buffer that hands result words out one at a time.
// Depends on ctt_pkg and ctt_token_if.
`default_nettype none

module ctt_drain (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ctt_pkg::t_bundle i_bun,
    input  wire logic             i_bun_valid,
    output logic                  o_bun_ready,
    ctt_token_if.source           o_tok
);
    import ctt_pkg::*;

    t_bundle             r_a, r_b;
    logic                r_a_valid, r_b_valid;
    logic [IDX_BITS-1:0] r_idx;

    logic  b_last, b_fire, b_done, a_move;
    t_item cur;

    assign cur    = r_b.items[r_idx];
    assign b_last = ({1'b0, r_idx} == (r_b.cnt - CNT_BITS'(1)));
    assign b_fire = r_b_valid && o_tok.ready;
    assign b_done = b_fire && b_last;
    assign a_move = r_a_valid && (!r_b_valid || b_done);

    assign o_bun_ready = !r_a_valid || a_move;

    // Holding stage: bundles without words are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_bun_valid && o_bun_ready && (i_bun.cnt != '0)) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bun_valid && o_bun_ready) begin
            r_a <= i_bun;
        end
    end

    // Output stage: steps through the words of one bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_idx     <= '0;
        end else if (a_move) begin
            r_b_valid <= 1'b1;
            r_idx     <= '0;
        end else if (b_done) begin
            r_b_valid <= 1'b0;
            r_idx     <= '0;
        end else if (b_fire) begin
            r_idx <= r_idx + IDX_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b <= r_a;
        end
    end

    assign o_tok.valid       = r_b_valid;
    assign o_tok.item_kind   = cur.kind;
    assign o_tok.token_char  = cur.ch;
    assign o_tok.token_line  = cur.line;
    assign o_tok.token_col   = cur.col;
    assign o_tok.last_of_run = b_last;

    // Checks
    a_b_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_b.cnt != '0) && ({1'b0, r_idx} < r_b.cnt))
        else $error("output index beyond bundle");

    a_a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> (r_a.cnt != '0))
        else $error("empty bundle held");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_fire && !b_last) |=> r_b_valid)
        else $error("run cut short");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_bun_ready |-> (r_a_valid && r_b_valid))
        else $error("input stalled with free buffer");

endmodule

`default_nettype wire

@@ sv/config_text_tokenizer_top.sv @@
// Top level of the configuration text tokenizer.
// Depends on ctt_pkg, ctt_if, ctt_lexer and ctt_drain.
//
// i_text takes one text byte per word (end_of_text set flushes the pending
// token and returns all counters and flags to their start values). o_token
// gives token words: a run of character words closed by an end word, each
// carrying the 1-based start line and column; last_of_run marks the final
// word caused by one input byte.
// The byte's bundle is registered in the holding stage when it is accepted
// and moves on, once the output stage is free, to that stage, which offers
// its words. A byte is taken every cycle while each byte causes at most one
// word and the receiver takes every word; a byte causing more holds the output
// until its words are taken, one per cycle while the receiver is ready.
// Two bundle stages sit between the scanner and the output, so one more bundle
// is taken while a finished word waits; once both are full, i_text.ready
// drops until the receiver takes the last word of the bundle on show.
// Synchronous reset clears the scanner state and both stages; no words are
// lost or invented across a stall.
`default_nettype none

module config_text_tokenizer_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ctt_text_if.sink    i_text,
    ctt_token_if.source o_token
);
    import ctt_pkg::*;

    t_bundle bun;
    logic    bun_valid, bun_ready;

    ctt_lexer u_lexer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_text      (i_text),
        .i_bun_ready (bun_ready),
        .o_bun       (bun),
        .o_bun_valid (bun_valid)
    );

    ctt_drain u_drain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bun       (bun),
        .i_bun_valid (bun_valid),
        .o_bun_ready (bun_ready),
        .o_tok       (o_token)
    );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for config_text_tokenizer_top: a directed table of bytes, then
// random text, then a short tail without idling, checked against an in-bench lexer or typed words.
// Depends on ctt_pkg, ctt_if and the tokenizer RTL.
`default_nettype none

module testbench;
    import ctt_pkg::*;

    // One expected or observed token word, fields in port order
    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        t_opos      line;
        t_opos      col;
        logic       last;
    } t_word;

    // Directed stimulus row; typed rows carry their two words written out
    typedef struct packed {
        logic [7:0] b;
        logic       eot;
        logic       typed;
        t_word      w0;
        t_word      w1;
    } t_dir_row;

    logic clk;
    logic rst_n;

    ctt_text_if  text_ch ();
    ctt_token_if tok_ch ();

    config_text_tokenizer_top uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_text  (text_ch),
        .o_token (tok_ch)
    );

    // Lexer state mirrored in the bench
    logic lx_comment;
    logic lx_quotes;
    logic lx_slash;
    logic lx_open;
    t_pos lx_start;
    t_pos lx_line;
    t_pos lx_col;
    t_pos lx_held;

    t_word step_words [MAX_ITEMS];
    int    step_n;

    t_word    words_due [$];
    t_dir_row dir_rows [$];

    int errors      = 0;
    int bytes_sent  = 0;
    int words_seen  = 0;
    int stall_left  = 0;
    bit idle_en     = 1'b0;

    // Clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    initial begin
        #8000000;
        $display("config_text_tokenizer_top test failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Lexer prediction
    // ---------------------------------------------------------------

    function automatic t_pos bump(input t_pos v);
        if (&v) return v;
        return v + t_pos'(1);
    endfunction

    // 0-based counter to 1-based reported position, clipped at the field maximum
    function automatic t_opos rep_pos(input t_pos v);
        longint unsigned x;
        x = longint'(v);
        if (x >= OUT_MAX) return t_opos'(OUT_MAX);
        return t_opos'(x + 1);
    endfunction

    function automatic void put_word(input logic kind, input logic [7:0] ch, input t_pos col);
        if (step_n < MAX_ITEMS) begin
            step_words[step_n] = {kind, ch, rep_pos(lx_line), rep_pos(col), 1'b0};
            step_n++;
        end
    endfunction

    function automatic void close_tok();
        if (lx_open) put_word(KIND_END, 8'h00, lx_start);
        lx_open = 1'b0;
    endfunction

    function automatic void add_char(input logic [7:0] ch, input t_pos col);
        if (!lx_open) begin
            lx_open  = 1'b1;
            lx_start = col;
        end
        put_word(KIND_CHAR, ch, lx_start);
    endfunction

    // A held slash that turned out not to open a comment becomes a plain character
    function automatic void drop_slash();
        if (lx_slash) add_char(CH_SLASH, lx_held);
        lx_slash = 1'b0;
    endfunction

    function automatic void lex_reset();
        lx_comment = 1'b0;
        lx_quotes  = 1'b0;
        lx_slash   = 1'b0;
        lx_open    = 1'b0;
        lx_start   = '0;
        lx_line    = '0;
        lx_col     = '0;
        lx_held    = '0;
    endfunction

    // Words caused by one text byte, left in step_words[0 .. step_n-1]
    function automatic void predict_step(input logic [7:0] b, input logic eot);
        t_pos cur;
        cur    = lx_col;
        step_n = 0;
        if (eot) begin
            drop_slash();
            close_tok();
            lex_reset();
        end else if (b == CH_LF) begin
            drop_slash();
            close_tok();
            lx_line    = bump(lx_line);
            lx_col     = '0;
            lx_comment = 1'b0;
            lx_quotes  = 1'b0;
        end else if (lx_comment) begin
            lx_col = bump(lx_col);
        end else if (lx_slash && b == CH_SLASH) begin
            // second slash: comment to end of line
            lx_slash   = 1'b0;
            close_tok();
            lx_comment = 1'b1;
            lx_col     = bump(lx_col);
        end else begin
            drop_slash();
            if (b == CH_SLASH) begin
                lx_slash = 1'b1;
                lx_held  = cur;
            end else if (b != CH_CR) begin
                if (b == CH_QUOTE) lx_quotes = !lx_quotes;
                if (b == CH_LBRACE || b == CH_RBRACE || b == CH_COMMA || b == CH_EQUALS) begin
                    close_tok();
                    put_word(KIND_CHAR, b, cur);
                    put_word(KIND_END, 8'h00, cur);
                end else if ((b == CH_SPACE || b == CH_TAB) && !lx_quotes) begin
                    close_tok();
                end else begin
                    add_char(b, cur);
                end
            end
            lx_col = bump(lx_col);
        end
        if (step_n > 0) step_words[step_n-1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic t_word wd(input logic kind, input logic [7:0] ch,
                                 input int line, input int col, input logic last);
        return {kind, ch, t_opos'(line), t_opos'(col), last};
    endfunction

    function automatic t_dir_row row_p(input logic [7:0] b, input logic eot);
        return {b, eot, 1'b0, t_word'(0), t_word'(0)};
    endfunction

    function automatic t_dir_row row_t(input logic [7:0] b, input logic eot,
                                       input t_word w0, input t_word w1);
        return {b, eot, 1'b1, w0, w1};
    endfunction

    // Append a row to the directed table
    function automatic void add_row(input t_dir_row r);
        dir_rows = {dir_rows, r};
    endfunction

    // Append a word to the expected stream
    function automatic void expect_word(input t_word w);
        words_due = {words_due, w};
    endfunction

    // Text-like byte mix: mostly identifiers and punctuation, some arbitrary bytes
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 8'h61 + 8'($urandom_range(0, 25));
        if (r < 48) return 8'h30 + 8'($urandom_range(0, 9));
        if (r < 53) return CH_SPACE;
        if (r < 56) return CH_TAB;
        if (r < 62) return CH_EQUALS;
        if (r < 66) return CH_COMMA;
        if (r < 70) return CH_LBRACE;
        if (r < 74) return CH_RBRACE;
        if (r < 79) return CH_QUOTE;
        if (r < 85) return CH_SLASH;
        if (r < 91) return CH_LF;
        if (r < 93) return CH_CR;
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one text word, wait for it to be taken, then record what it must cause
    task automatic send_byte(input logic [7:0] b, input logic eot,
                             input logic typed = 1'b0,
                             input t_word w0 = '0, input t_word w1 = '0);
        int gap;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid       <= 1'b1;
        text_ch.text_byte   <= b;
        text_ch.end_of_text <= eot;
        do @(posedge clk); while (!text_ch.ready);
        bytes_sent++;
        predict_step(b, eot);
        if (typed) begin
            expect_word(w0);
            expect_word(w1);
        end else begin
            for (int i = 0; i < step_n; i++) expect_word(step_words[i]);
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stall bursts while idling is enabled
    // ---------------------------------------------------------------
    initial begin
        tok_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (idle_en && stall_left > 0) begin
                stall_left--;
                tok_ch.ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 9);
                tok_ch.ready <= 1'b0;
            end else begin
                tok_ch.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Checker: every word taken is compared with the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        t_word got;
        t_word want;
        if (rst_n && tok_ch.valid && tok_ch.ready) begin
            got = {tok_ch.item_kind, tok_ch.token_char, tok_ch.token_line,
                   tok_ch.token_col, tok_ch.last_of_run};
            words_seen++;
            if (words_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected word kind %0d char %02h line %0d col %0d last %0d",
                         $time, got.kind, got.ch, got.line, got.col, got.last);
            end else begin
                want = words_due.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: mismatch expected kind %0d char %02h line %0d col %0d last %0d",
                             $time, want.kind, want.ch, want.line, want.col, want.last);
                    $display("%0t:          actual   kind %0d char %02h line %0d col %0d last %0d",
                             $time, got.kind, got.ch, got.line, got.col, got.last);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int n_dir;
        int n_rand;
        int run;

        rst_n               <= 1'b0;
        text_ch.valid       <= 1'b0;
        text_ch.text_byte   <= 8'h00;
        text_ch.end_of_text <= 1'b0;
        lex_reset();

        // Directed table: punctuation, separators, quotes, comments, held slash cases
        add_row(row_t(CH_LBRACE, 1'b0, wd(KIND_CHAR, CH_LBRACE, 1, 1, 1'b0),
                                       wd(KIND_END, 8'h00, 1, 1, 1'b1)));
        add_row(row_p("a", 1'b0));
        add_row(row_p(8'h00, 1'b0));
        add_row(row_p(CH_SPACE, 1'b0));
        add_row(row_p(CH_TAB, 1'b0));
        add_row(row_p(CH_QUOTE, 1'b0));
        add_row(row_p(CH_SPACE, 1'b0));       // space kept inside quotes
        add_row(row_p(CH_SLASH, 1'b0));
        add_row(row_p(CH_SLASH, 1'b0));       // comment even within quotes
        add_row(row_p(CH_RBRACE, 1'b0));      // swallowed by the comment
        add_row(row_p(CH_LF, 1'b0));
        add_row(row_p(8'hFF, 1'b0));
        add_row(row_p(CH_SLASH, 1'b0));
        add_row(row_p("x", 1'b0));            // lone slash released
        add_row(row_p(CH_CR, 1'b0));
        add_row(row_p(CH_EQUALS, 1'b0));
        add_row(row_p(CH_SLASH, 1'b0));
        add_row(row_p(CH_LF, 1'b0));          // slash released at newline
        add_row(row_t(CH_COMMA, 1'b0, wd(KIND_CHAR, CH_COMMA, 3, 1, 1'b0),
                                      wd(KIND_END, 8'h00, 3, 1, 1'b1)));
        add_row(row_p("q", 1'b0));
        add_row(row_p(CH_SLASH, 1'b0));
        add_row(row_p(CH_SLASH, 1'b1));       // end of text, byte ignored
        add_row(row_t(CH_RBRACE, 1'b0, wd(KIND_CHAR, CH_RBRACE, 1, 1, 1'b0),
                                       wd(KIND_END, 8'h00, 1, 1, 1'b1)));
        add_row(row_p("k", 1'b0));
        add_row(row_p(CH_SLASH, 1'b0));
        add_row(row_p(CH_LBRACE, 1'b0));      // four words from one byte
        add_row(row_p(8'hA5, 1'b1));          // end of text, nothing pending

        repeat (2) @(posedge clk);
        rst_n   <= 1'b1;
        idle_en = 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].b, dir_rows[i].eot, dir_rows[i].typed,
                      dir_rows[i].w0, dir_rows[i].w1);
        n_dir = bytes_sent;

        // Random text in chunks, idling switched per chunk
        n_rand = 0;
        while (n_rand < 360) begin
            if (n_rand % 50 == 0) idle_en = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 59) == 0) begin
                send_byte(8'($urandom_range(0, 255)), 1'b1);
                n_rand++;
            end else if ($urandom_range(0, 24) == 0) begin
                // whole comment line
                send_byte(CH_SLASH, 1'b0);
                send_byte(CH_SLASH, 1'b0);
                run = $urandom_range(0, 6);
                repeat (run) send_byte(pick_byte(), 1'b0);
                send_byte(CH_LF, 1'b0);
                n_rand += run + 3;
            end else begin
                send_byte(pick_byte(), 1'b0);
                n_rand++;
            end
        end

        // Last part without idling: back-to-back text, then end of text
        idle_en = 1'b0;
        repeat (12) send_byte(pick_byte(), 1'b0);
        send_byte(CH_LF, 1'b1);
        text_ch.valid <= 1'b0;

        while (words_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d text bytes (%0d from the directed table, the rest random text),",
                 bytes_sent, n_dir);
        $display("checked %0d token words with %0d mismatches.", words_seen, errors);
        if (errors == 0 && words_due.size() == 0) begin
            $display("config_text_tokenizer_top test passed");
        end else begin
            $display("config_text_tokenizer_top test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
sv/ctt_pkg.sv
sv/ctt_if.sv
sv/ctt_lexer.sv
sv/ctt_drain.sv
sv/config_text_tokenizer_top.sv
tb/testbench.sv
